// ----- src/building_net_pdu_function_filter_defines.svh -----
// Assertion macros for the BACnet header classifier.
// No dependencies; included by the top level only.
`ifndef BUILDING_NET_PDU_FUNCTION_FILTER_DEFINES_SVH
`define BUILDING_NET_PDU_FUNCTION_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BNPFF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("classifier assertion failed");

// Next-cycle implication, disabled while in reset.
`define BNPFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("classifier assertion failed");

`endif

// ----- src/bnpff_pkg.sv -----
// Shared types and constants for the BACnet header classifier.
// No dependencies.
package bnpff_pkg;

  localparam int CODE_W  = 9;
  localparam int APDU_W  = 5;
  localparam int MASK_W  = 32;
  localparam int CFG_IW  = 3;
  localparam int QDEPTH  = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IW-1:0] REG_BVLC_MASK  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_NET_MASK   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_APDU_MASK  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CONF_MASK  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_UNCF_MASK  = 3'd4;

  // Codes captured from one packet; all-ones (-1) means absent
  typedef struct packed {
    logic [CODE_W-1:0] uncf;
    logic [CODE_W-1:0] conf;
    logic [APDU_W-1:0] apdu;
    logic [CODE_W-1:0] net;
    logic [CODE_W-1:0] bvlc;
  } codes_t;

  localparam codes_t CODES_NONE = '{uncf: '1, conf: '1, apdu: '1, net: '1, bvlc: '1};

  // Queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

endpackage

// ----- src/bnpff_parser.sv -----
// Front end: per-byte header parser, emits one code record per packet.
// Depends on bnpff_pkg.
module bnpff_parser #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_en,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                push,
  output bnpff_pkg::codes_t   rec
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_PACKET_BYTES);

  localparam logic [3:0] PH_FIRST    = 4'd0;
  localparam logic [3:0] PH_BVLC_FN  = 4'd1;
  localparam logic [3:0] PH_BVLC_LEN = 4'd2;
  localparam logic [3:0] PH_ORIG     = 4'd3;
  localparam logic [3:0] PH_VERSION  = 4'd4;
  localparam logic [3:0] PH_CTRL     = 4'd5;
  localparam logic [3:0] PH_DNET     = 4'd6;
  localparam logic [3:0] PH_DLEN     = 4'd7;
  localparam logic [3:0] PH_DADR     = 4'd8;
  localparam logic [3:0] PH_SNET     = 4'd9;
  localparam logic [3:0] PH_SLEN     = 4'd10;
  localparam logic [3:0] PH_SADR     = 4'd11;
  localparam logic [3:0] PH_HOP      = 4'd12;
  localparam logic [3:0] PH_BODY     = 4'd13;
  localparam logic [3:0] PH_SERVICE  = 4'd14;
  localparam logic [3:0] PH_DONE     = 4'd15;

  // flag bits: [2] network message, [1] DNET present, [0] SNET present
  logic [3:0]        phase, phase_next;
  logic [PW-1:0]     pos;
  logic [7:0]        skip, skip_next, skip_dec;
  logic [2:0]        flags, flags_next;
  bnpff_pkg::codes_t codes, codes_next;
  logic              parse_en;
  logic [3:0]        apdu_t;
  logic [2:0]        svc_off;

  assign parse_en = byte_en && (pos < POS_MAX);
  assign skip_dec = skip - 8'd1;
  assign apdu_t   = data_byte[7:4];

  function automatic logic [3:0] after_src(input logic [2:0] f);
    return f[1] ? PH_HOP : PH_BODY;
  endfunction

  always_comb begin
    case (apdu_t)
      4'd0:    svc_off = data_byte[3] ? 3'd5 : 3'd3;
      4'd1:    svc_off = 3'd1;
      4'd2:    svc_off = 3'd2;
      4'd3:    svc_off = data_byte[3] ? 3'd4 : 3'd2;
      4'd5:    svc_off = 3'd2;
      default: svc_off = 3'd0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    skip_next  = skip;
    flags_next = flags;
    codes_next = codes;
    if (parse_en) begin
      unique case (phase)
        PH_FIRST: begin
          if (data_byte == 8'h81) phase_next = PH_BVLC_FN;
          else if (data_byte == 8'h01) phase_next = PH_CTRL;
          else phase_next = PH_DONE;
        end
        PH_BVLC_FN: begin
          codes_next.bvlc = {1'b0, data_byte};
          phase_next = PH_BVLC_LEN;
          skip_next  = 8'd2;
        end
        PH_BVLC_LEN: begin
          skip_next = skip_dec;
          if (skip_dec == 8'd0) begin
            if (codes.bvlc == 9'd4) begin
              phase_next = PH_ORIG;
              skip_next  = 8'd6;
            end else if (codes.bvlc <= 9'd8) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_VERSION;
            end
          end
        end
        PH_ORIG: begin
          skip_next = skip_dec;
          if (skip_dec == 8'd0) phase_next = PH_VERSION;
        end
        PH_VERSION: begin
          phase_next = (data_byte == 8'h01) ? PH_CTRL : PH_DONE;
        end
        PH_CTRL: begin
          flags_next = {data_byte[7], data_byte[5], data_byte[3]};
          if (data_byte[5]) begin
            phase_next = PH_DNET;
            skip_next  = 8'd2;
          end else if (data_byte[3]) begin
            phase_next = PH_SNET;
            skip_next  = 8'd2;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_DNET: begin
          skip_next = skip_dec;
          if (skip_dec == 8'd0) phase_next = PH_DLEN;
        end
        PH_DLEN, PH_DADR: begin
          if (phase == PH_DLEN && data_byte != 8'd0) begin
            phase_next = PH_DADR;
            skip_next  = data_byte;
          end else if (phase == PH_DLEN || skip_dec == 8'd0) begin
            if (phase == PH_DADR) skip_next = skip_dec;
            if (flags[0]) begin
              phase_next = PH_SNET;
              skip_next  = 8'd2;
            end else begin
              phase_next = after_src(flags);
            end
          end else begin
            skip_next = skip_dec;
          end
        end
        PH_SNET: begin
          skip_next = skip_dec;
          if (skip_dec == 8'd0) phase_next = PH_SLEN;
        end
        PH_SLEN: begin
          if (data_byte != 8'd0) begin
            phase_next = PH_SADR;
            skip_next  = data_byte;
          end else begin
            phase_next = after_src(flags);
          end
        end
        PH_SADR: begin
          skip_next = skip_dec;
          if (skip_dec == 8'd0) phase_next = after_src(flags);
        end
        PH_HOP: phase_next = PH_BODY;
        PH_BODY: begin
          if (flags[2]) begin
            codes_next.net = {1'b0, data_byte};
            phase_next = PH_DONE;
          end else begin
            codes_next.apdu = {1'b0, apdu_t};
            if (svc_off == 3'd0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_SERVICE;
              skip_next  = {5'd0, svc_off - 3'd1};
            end
          end
        end
        PH_SERVICE: begin
          if (skip != 8'd0) begin
            skip_next = skip_dec;
          end else begin
            if (codes.apdu == 5'd1) codes_next.uncf = {1'b0, data_byte};
            else codes_next.conf = {1'b0, data_byte};
            phase_next = PH_DONE;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  assign push = byte_en && last_byte;
  assign rec  = codes_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase <= PH_FIRST;
      pos   <= '0;
      skip  <= '0;
      flags <= '0;
      codes <= bnpff_pkg::CODES_NONE;
    end else begin
      phase <= phase_next;
      skip  <= skip_next;
      flags <= flags_next;
      codes <= codes_next;
      if (parse_en) pos <= pos + PW'(1);
    end
  end

endmodule

// ----- src/bnpff_queue.sv -----
// Short record queue between the parser and the match stage.
// Depends on bnpff_pkg.
module bnpff_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bnpff_pkg::codes_t   push_rec,
  input  logic                pop,
  output bnpff_pkg::codes_t   head,
  output bnpff_pkg::qstat_t   stat
);

  localparam int AW = $clog2(bnpff_pkg::QDEPTH);

  bnpff_pkg::codes_t mem [bnpff_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign stat.full  = (count == (AW+1)'(bnpff_pkg::QDEPTH));
  assign stat.valid = (count != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ----- src/bnpff_matcher.sv -----
// Back end: mask registers, function match and the output register.
// Depends on bnpff_pkg.
module bnpff_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bnpff_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bnpff_pkg::MASK_W-1:0]  cfg_data,
  input  bnpff_pkg::codes_t             head,
  input  bnpff_pkg::qstat_t             qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bnpff_pkg::codes_t             out_codes,
  output logic                          out_match
);

  logic [bnpff_pkg::MASK_W-1:0] bvlc_mask, net_mask, apdu_mask, conf_mask, uncf_mask;
  logic hit;

  // code hits when it is present, below 32 and its mask bit is set
  function automatic logic code_hit(input logic [8:0] code,
                                    input logic [bnpff_pkg::MASK_W-1:0] mask);
    return !code[8] && (code[7:5] == 3'd0) && mask[code[4:0]];
  endfunction

  assign hit = code_hit(head.bvlc, bvlc_mask) || code_hit(head.net, net_mask)
            || code_hit({{4{head.apdu[4]}}, head.apdu}, apdu_mask)
            || code_hit(head.conf, conf_mask) || code_hit(head.uncf, uncf_mask);

  assign pop = qstat.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      bvlc_mask <= '0;
      net_mask  <= '0;
      apdu_mask <= '0;
      conf_mask <= '0;
      uncf_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bnpff_pkg::REG_BVLC_MASK: bvlc_mask <= cfg_data;
        bnpff_pkg::REG_NET_MASK:  net_mask  <= cfg_data;
        bnpff_pkg::REG_APDU_MASK: apdu_mask <= cfg_data;
        bnpff_pkg::REG_CONF_MASK: conf_mask <= cfg_data;
        bnpff_pkg::REG_UNCF_MASK: uncf_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_codes <= head;
      out_match <= hit;
    end
  end

endmodule

// ----- src/building_net_pdu_function_filter.sv -----
// BACnet/IP header classifier: one byte per item in, one result per packet out.
// Throughput: one byte per cycle; s_tready drops only while the 4-entry result queue is full.
// Result path: the record is written to the queue at the edge that accepts the last byte,
// then moved into the match/output register when that register is empty or being read.
// Reset: synchronous rst clears parse state, queue, output valid and all mask registers.
// Depends on bnpff_pkg, bnpff_parser, bnpff_queue, bnpff_matcher and the defines header.
`include "building_net_pdu_function_filter_defines.svh"

module building_net_pdu_function_filter #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [7:0] data_byte
  input  logic                          s_tlast,  // last_byte
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [8:0] bvlc_function, [17:9] network_function, [22:18] apdu_type,
  // [31:23] confirmed_service, [40:32] unconfirmed_service, [47:41] zero
  output logic [47:0]                   m_tdata,
  output logic [0:0]                    m_tuser,  // [0] function_match
  // configuration writes
  input  logic                          cfg_we,
  input  logic [bnpff_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bnpff_pkg::MASK_W-1:0]  cfg_data
);

  logic              byte_en;
  logic              push;
  logic              pop;
  logic              out_match;
  bnpff_pkg::codes_t rec, head, out_codes;
  bnpff_pkg::qstat_t qstat;

  // Front end stalls on the queue only; the output register never blocks
  // it directly.
  assign s_tready = !qstat.full;
  assign byte_en  = s_tvalid && s_tready;

  bnpff_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_en),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .push      (push),
    .rec       (rec)
  );

  // Decouples packet parsing from the downstream consumer.
  bnpff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  bnpff_matcher u_matcher (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_codes (out_codes),
    .out_match (out_match)
  );

  assign m_tdata = {7'd0, out_codes.uncf, out_codes.conf, out_codes.apdu,
                    out_codes.net, out_codes.bvlc};
  assign m_tuser = out_match;

  // A packet end always leaves a record waiting in the queue.
  `BNPFF_ASSERT_NEXT(a_push_lands, byte_en && s_tlast, qstat.valid)
  // A new result only appears when the queue had one to give.
  `BNPFF_ASSERT_IMPLY(a_rise_from_queue, $rose(m_tvalid), $past(qstat.valid))
  // A match needs at least one present code.
  `BNPFF_ASSERT_IMPLY(a_match_has_code, m_tvalid && m_tuser[0],
    !(m_tdata[8] && m_tdata[17] && m_tdata[22] && m_tdata[31] && m_tdata[40]))

endmodule
